FILE: hw/rtl/mpsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsa_pkg: shared types and constants for the macroblock pixel store addresser
// Field widths, plane codes, block index codes and the payload structs that
// travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package mpsa_pkg;

    localparam int WIDTH_W  = 13;   // picture width register
    localparam int MBA_W    = 16;   // macroblock address
    localparam int MBW_W    = 9;    // macroblocks per row (width / 16)
    localparam int OFF_W    = 24;   // pixel offset within a plane
    localparam int PIX_W    = 8;
    localparam int SAMPLE_W = 16;
    localparam int BLK_W    = 3;
    localparam int POS_W    = 3;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd720;

    // block index codes: 0..3 luma, then the two chroma blocks
    localparam logic [BLK_W-1:0] BLK_CR = 3'd4;
    localparam logic [BLK_W-1:0] BLK_CB = 3'd5;

    typedef enum logic [1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_CR   = 2'd1,
        PLANE_CB   = 2'd2
    } t_plane;

    // classified item: everything but the macroblock split is resolved
    typedef struct packed {
        logic [MBA_W-1:0] mba;
        t_plane           plane;
        logic [OFF_W-1:0] local_off;
        logic [PIX_W-1:0] pixel;
    } t_item;

    // one stage of the restoring divider
    typedef struct packed {
        logic [MBW_W-1:0] rem;
        logic [MBA_W-1:0] dvd;
        logic [MBA_W-1:0] quo;
        t_item            item;
    } t_div;

endpackage

FILE: hw/rtl/mpsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsa_front: input stage
// Registers each input beat, drops skipped macroblocks and unused block
// indexes, clamps the sample and resolves the offset inside the macroblock.
// ----------------------------------------------------------------------------
module mpsa_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mpsa_pkg::WIDTH_W-1:0]      i_picture_width,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mpsa_pkg::MBA_W-1:0]        i_mb_address,
    input  logic                              i_field_dct,
    input  logic                              i_skip_mb,
    input  logic [mpsa_pkg::BLK_W-1:0]        i_block_index,
    input  logic [mpsa_pkg::POS_W-1:0]        i_row,
    input  logic [mpsa_pkg::POS_W-1:0]        i_col,
    input  logic signed [mpsa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_push,
    input  logic                              i_q_ready,
    output mpsa_pkg::t_item                   o_item
);
    import mpsa_pkg::*;

    logic            r_valid;
    logic            r_keep;
    t_item           r_item;
    t_item           n_item;
    logic            w_keep;
    logic            w_luma;
    logic [13:0]     w_pitch;
    logic [15:0]     w_lower;
    logic [16:0]     w_row_off;
    logic [17:0]     w_luma_off;
    logic [14:0]     w_chroma_off;

    // classify: skipped macroblocks and block indexes past Cb give nothing
    assign w_keep = !i_skip_mb && (i_block_index <= BLK_CB);
    assign w_luma = (i_block_index < BLK_CR);

    // field DCT: rows at twice the pitch, lower blocks start one line down
    assign w_pitch   = i_field_dct ? {i_picture_width, 1'b0} : {1'b0, i_picture_width};
    assign w_lower   = i_field_dct ? {3'b000, i_picture_width} : {i_picture_width, 3'b000};
    assign w_row_off = 17'(i_row) * 17'(w_pitch);

    assign w_luma_off = (i_block_index[1] ? 18'(w_lower) : 18'd0)
                      + (i_block_index[0] ? 18'd8 : 18'd0)
                      + 18'(w_row_off) + 18'(i_col);
    assign w_chroma_off = 15'(i_row) * 15'(i_picture_width[WIDTH_W-1:1]) + 15'(i_col);

    always_comb begin
        n_item.mba       = i_mb_address;
        n_item.local_off = w_luma ? OFF_W'(w_luma_off) : OFF_W'(w_chroma_off);
        if (w_luma) begin
            n_item.plane = PLANE_LUMA;
        end else if (i_block_index == BLK_CR) begin
            n_item.plane = PLANE_CR;
        end else begin
            n_item.plane = PLANE_CB;
        end
        // saturate to 0..255
        if (i_sample[SAMPLE_W-1]) begin
            n_item.pixel = '0;
        end else if (|i_sample[SAMPLE_W-2:PIX_W]) begin
            n_item.pixel = '1;
        end else begin
            n_item.pixel = i_sample[PIX_W-1:0];
        end
    end

    // a dropped beat never waits on the queue
    assign o_ready = !r_valid || !r_keep || i_q_ready;
    assign o_push  = r_valid && r_keep;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
            r_keep <= w_keep;
        end
    end

endmodule

FILE: hw/rtl/mpsa_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsa_fifo: item queue
// Small register queue between the front end and the back end so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module mpsa_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  mpsa_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output mpsa_pkg::t_item o_item
);
    import mpsa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: hw/rtl/mpsa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsa_back: macroblock split and offset assembly
// Pipelined restoring divider splits the macroblock address into column
// and row, one quotient bit per stage, then one multiply stage and the
// output register build the final plane offset.
// ----------------------------------------------------------------------------
module mpsa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mpsa_pkg::WIDTH_W-1:0]  i_picture_width,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  mpsa_pkg::t_item               i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_plane,
    output logic [mpsa_pkg::OFF_W-1:0]    o_byte_offset,
    output logic [mpsa_pkg::PIX_W-1:0]    o_pixel
);
    import mpsa_pkg::*;

    localparam int NSTG = MBA_W;   // one quotient bit per stage

    logic [MBW_W-1:0]   w_mbw;
    logic               w_mbw_zero;
    logic               w_en;

    logic [NSTG:0]      r_div_valid;
    t_div               r_div [NSTG+1];
    t_div               n_div [NSTG+1];

    logic               r_mul_valid;
    t_item              r_mul_item;
    logic [OFF_W-1:0]   r_mul_prod;
    logic [OFF_W-1:0]   r_mul_mx;
    logic [MBA_W-1:0]   w_mx;
    logic [MBA_W-1:0]   w_my;
    logic [WIDTH_W-1:0] w_mulw;
    logic [28:0]        w_prod;
    logic               w_mul_luma;
    logic [OFF_W-1:0]   w_row_term;

    logic               r_out_valid;
    t_plane             r_out_plane;
    logic [OFF_W-1:0]   r_out_off;
    logic [PIX_W-1:0]   r_out_pixel;

    assign w_mbw      = i_picture_width[WIDTH_W-1:4];
    assign w_mbw_zero = (w_mbw == '0);

    // the whole pipeline moves when the output register frees up
    assign w_en  = !r_out_valid || i_ready;
    assign o_pop = w_en && i_valid;

    // divider entry
    always_comb begin
        n_div[0].rem  = '0;
        n_div[0].dvd  = i_item.mba;
        n_div[0].quo  = '0;
        n_div[0].item = i_item;
    end

    // one restoring step per stage
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        logic [MBW_W:0] w_trial;
        logic [MBW_W:0] w_diff;
        logic           w_ge;

        assign w_trial = {r_div[k].rem, r_div[k].dvd[MBA_W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_mbw});
        assign w_diff  = w_trial - {1'b0, w_mbw};

        always_comb begin
            n_div[k+1].rem  = w_ge ? w_diff[MBW_W-1:0] : w_trial[MBW_W-1:0];
            n_div[k+1].dvd  = {r_div[k].dvd[MBA_W-2:0], 1'b0};
            n_div[k+1].quo  = {r_div[k].quo[MBA_W-2:0], w_ge};
            n_div[k+1].item = r_div[k].item;
        end
    end

    for (genvar k = 0; k <= NSTG; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_div_valid[k] <= (k == 0) ? i_valid : r_div_valid[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // multiply stage: row term; a zero macroblock width leaves the address whole
    assign w_mul_luma = (r_div[NSTG].item.plane == PLANE_LUMA);
    assign w_mx   = w_mbw_zero ? r_div[NSTG].item.mba : MBA_W'(r_div[NSTG].rem);
    assign w_my   = w_mbw_zero ? '0 : r_div[NSTG].quo;
    assign w_mulw = w_mul_luma ? i_picture_width : {1'b0, i_picture_width[WIDTH_W-1:1]};
    assign w_prod = 29'(w_my) * 29'(w_mulw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (w_en) begin
            r_mul_valid <= r_div_valid[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul_item <= r_div[NSTG].item;
            r_mul_prod <= w_prod[OFF_W-1:0];
            r_mul_mx   <= w_mul_luma ? OFF_W'({w_mx, 4'b0000}) : OFF_W'({w_mx, 3'b000});
        end
    end

    // output register: luma rows of macroblocks are 16 lines, chroma 8
    assign w_row_term = (r_mul_item.plane == PLANE_LUMA)
                      ? {r_mul_prod[OFF_W-5:0], 4'b0000}
                      : {r_mul_prod[OFF_W-4:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_plane <= r_mul_item.plane;
            r_out_off   <= r_mul_mx + w_row_term + r_mul_item.local_off;
            r_out_pixel <= r_mul_item.pixel;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_plane       = r_out_plane;
    assign o_byte_offset = r_out_off;
    assign o_pixel       = r_out_pixel;

endmodule

FILE: hw/rtl/macroblock_pixel_store_addresser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macroblock_pixel_store_addresser: intra macroblock pixel store addresser
// Turns tagged reconstructed samples into plane, plane offset and pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per reconstructed sample, tagged with macroblock
//   address, block index, row and column; tuser carries the DCT type and
//   the skip flag. Skipped macroblocks and block indexes 6 and 7 give no
//   result beat. Master stream: one beat per kept sample, in input order,
//   with the plane in tuser and offset and clamped pixel in tdata.
//   picture_width is written through i_cfg_wr_en / i_cfg_wr_data while no
//   beat is in flight; it resets to 720.
//   Throughput: one beat per cycle, sustained, in both directions while
//   m_axis_tready stays high. Path from input accept to output valid:
//   input register, queue, 17 registers of the 16-step divider that
//   splits the macroblock address, the multiply stage, output register.
//   When the receiver stalls, the back pipeline holds, the queue fills,
//   and only then does s_axis_tready drop.
//   Reset (synchronous, active low) empties every stage and the queue.
// ----------------------------------------------------------------------------
module macroblock_pixel_store_addresser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic [mpsa_pkg::WIDTH_W-1:0] i_cfg_wr_data,
    // slave stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] mb_address, [18:16] block_index, [21:19] row, [24:22] col,
    // [40:25] sample, [47:41] zero
    input  logic [47:0]                  s_axis_tdata,
    // [0] field_dct, [1] skip_mb
    input  logic [1:0]                   s_axis_tuser,
    // master stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [23:0] byte_offset, [31:24] pixel
    output logic [31:0]                  m_axis_tdata,
    // [1:0] plane
    output logic [1:0]                   m_axis_tuser
);
    import mpsa_pkg::*;

    logic [WIDTH_W-1:0] r_picture_width;
    logic               w_q_push;
    logic               w_q_ready;
    t_item              w_front_item;
    logic               w_q_valid;
    logic               w_q_pop;
    t_item              w_q_item;
    logic [OFF_W-1:0]   w_byte_offset;
    logic [PIX_W-1:0]   w_pixel;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_picture_width <= WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_picture_width <= i_cfg_wr_data;
        end
    end

    mpsa_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_picture_width (r_picture_width),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_mb_address    (s_axis_tdata[15:0]),
        .i_field_dct     (s_axis_tuser[0]),
        .i_skip_mb       (s_axis_tuser[1]),
        .i_block_index   (s_axis_tdata[18:16]),
        .i_row           (s_axis_tdata[21:19]),
        .i_col           (s_axis_tdata[24:22]),
        .i_sample        (s_axis_tdata[40:25]),
        .o_push          (w_q_push),
        .i_q_ready       (w_q_ready),
        .o_item          (w_front_item)
    );

    mpsa_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .o_ready (w_q_ready),
        .i_item  (w_front_item),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    mpsa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_picture_width (r_picture_width),
        .i_valid         (w_q_valid),
        .o_pop           (w_q_pop),
        .i_item          (w_q_item),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_plane         (m_axis_tuser),
        .o_byte_offset   (w_byte_offset),
        .o_pixel         (w_pixel)
    );

    assign m_axis_tdata = {w_pixel, w_byte_offset};

    // assertions
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push && !w_q_ready |-> !s_axis_tready)
        else $error("front stage dropped a beat into a full queue");

    a_plane_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == PLANE_LUMA || m_axis_tuser == PLANE_CR
                           || m_axis_tuser == PLANE_CB))
        else $error("result beat with an unused plane code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !w_q_valid)
        else $error("pipeline not empty after reset");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back end popped an empty queue");

endmodule
